>>> rtl/bitmap_text_layout_assert.svh
// Assertion macros for the bitmap text layout block.
`ifndef BITMAP_TEXT_LAYOUT_ASSERT_SVH
`define BITMAP_TEXT_LAYOUT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BTL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap_text_layout: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define BTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap_text_layout: next-cycle check failed");

`endif

>>> rtl/btl_pkg.sv
// Types and constants shared by the bitmap text layout modules.
`timescale 1ns / 1ps
`default_nettype none

package btl_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CHAR  = 2'd2,
        OP_END   = 2'd3
    } t_opcode;

    localparam logic [1:0] CLASS_MISSING  = 2'd0;
    localparam logic [1:0] CLASS_DRAWABLE = 2'd1;

    localparam logic KIND_SPRITE = 1'b0;
    localparam logic KIND_DIMS   = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;

    localparam logic [7:0] LINE_HEIGHT_RESET = 8'd16;

    localparam int IN_DATA_BITS  = 104;
    localparam int OUT_DATA_BITS = 136;

    typedef struct packed {
        logic [1:0]  glyph_class;
        logic [10:0] atlas_y;
        logic [10:0] atlas_x;
        logic [7:0]  width;
    } t_glyph_entry;

    typedef struct packed {
        logic [31:0] text_color;
        logic [15:0] origin_y;
        logic [15:0] origin_x;
        logic [1:0]  glyph_class;
        logic [10:0] glyph_atlas_y;
        logic [10:0] glyph_atlas_x;
        logic [7:0]  glyph_width;
        logic [7:0]  char_code;
    } t_in_data;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] measured_height;
        logic [15:0] measured_width;
        logic [31:0] draw_color;
        logic [10:0] source_y;
        logic [10:0] source_x;
        logic [7:0]  sprite_height;
        logic [7:0]  sprite_width;
        logic [15:0] dest_y;
        logic [15:0] dest_x;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/bitmap_text_layout.sv
// Path: input transfer -> stage 1 and glyph table read -> output register.
// Throughput: one item per cycle unless stalled; the single glyph read port sets this rate.
// Stalls: input is held off only while a result waits in a full, stalled output register.
// Reset: synchronous active-low reset clears pen, origin, color, line height (16) and
// the pipeline valid flags; the glyph table is not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_text_layout #(
    parameter int GLYPH_COUNT = 256,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [7:0]                        i_cfg_wr_data,   // line_height
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // char_code, glyph_width, glyph_atlas_x, glyph_atlas_y, glyph_class,
    // origin_x, origin_y, text_color
    input  wire logic [btl_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input  wire logic [1:0]                        s_axis_tuser,    // opcode
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // dest_x, dest_y, sprite_width, sprite_height, source_x, source_y,
    // draw_color, measured_width, measured_height, two zero bits
    output logic [btl_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    output logic                                   m_axis_tuser     // result_kind
);

    localparam int IDX_BITS = $clog2(GLYPH_COUNT);

    btl_pkg::t_in_data     in_data;
    btl_pkg::t_opcode      in_op;
    logic                  in_fire;
    logic                  in_range;
    logic [31:0]           origin_x_wide;
    logic [31:0]           origin_y_wide;
    btl_pkg::t_glyph_entry wr_entry;
    btl_pkg::t_glyph_entry rd_entry;

    logic [7:0]            r_line_height;
    btl_pkg::t_glyph_entry r_qmark;

    logic                  r_s1_valid;
    btl_pkg::t_opcode      r_s1_op;
    logic                  r_s1_newline;
    logic                  r_s1_in_range;
    logic [COORD_BITS-1:0] r_s1_origin_x;
    logic [COORD_BITS-1:0] r_s1_origin_y;
    logic [31:0]           r_s1_color;

    logic [COORD_BITS-1:0] r_pen_x;
    logic [COORD_BITS-1:0] r_pen_y;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [31:0]           r_color;

    logic                  r_out_valid;
    logic                  r_out_kind;
    btl_pkg::t_result      r_out_data;

    btl_pkg::t_glyph_entry s1_raw;
    btl_pkg::t_glyph_entry s1_entry;
    logic                  s1_drawn;
    logic                  s1_has_result;
    logic                  s1_go;
    logic                  out_free;
    logic [COORD_BITS-1:0] meas_w;
    logic [COORD_BITS-1:0] meas_h;
    logic [31:0]           pen_x_wide;
    logic [31:0]           pen_y_wide;
    logic [31:0]           meas_w_wide;
    logic [31:0]           meas_h_wide;
    logic                  n_out_kind;
    btl_pkg::t_result      n_out_data;

    assign in_data       = btl_pkg::t_in_data'(s_axis_tdata);
    assign in_op         = btl_pkg::t_opcode'(s_axis_tuser);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_range      = ({1'b0, in_data.char_code} < 9'(GLYPH_COUNT));
    assign origin_x_wide = 32'(signed'(in_data.origin_x));
    assign origin_y_wide = 32'(signed'(in_data.origin_y));

    assign wr_entry.glyph_class = in_data.glyph_class;
    assign wr_entry.atlas_y     = in_data.glyph_atlas_y;
    assign wr_entry.atlas_x     = in_data.glyph_atlas_x;
    assign wr_entry.width       = in_data.glyph_width;

    btl_glyph_ram #(
        .DEPTH     (GLYPH_COUNT),
        .ADDR_BITS (IDX_BITS)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire && (in_op == btl_pkg::OP_WRITE) && in_range),
        .i_wr_addr (in_data.char_code[IDX_BITS-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_data.char_code[IDX_BITS-1:0]),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire && (in_op == btl_pkg::OP_WRITE)
                && (in_data.char_code == btl_pkg::CHAR_QUESTION)) begin
            r_qmark <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_height <= btl_pkg::LINE_HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_height <= i_cfg_wr_data;
        end
    end

    assign s1_raw        = r_s1_in_range ? rd_entry : '0;
    assign s1_entry      = (s1_raw.glyph_class == btl_pkg::CLASS_MISSING) ? r_qmark : s1_raw;
    assign s1_drawn      = (s1_entry.glyph_class == btl_pkg::CLASS_DRAWABLE);
    assign s1_has_result = (r_s1_op == btl_pkg::OP_END)
                        || ((r_s1_op == btl_pkg::OP_CHAR) && !r_s1_newline && s1_drawn);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && (!s1_has_result || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op       <= in_op;
            r_s1_newline  <= (in_data.char_code == btl_pkg::CHAR_NEWLINE);
            r_s1_in_range <= in_range;
            r_s1_origin_x <= origin_x_wide[COORD_BITS-1:0];
            r_s1_origin_y <= origin_y_wide[COORD_BITS-1:0];
            r_s1_color    <= in_data.text_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_color   <= '0;
        end else if (s1_go) begin
            case (r_s1_op)
                btl_pkg::OP_BEGIN: begin
                    r_start_x <= r_s1_origin_x;
                    r_start_y <= r_s1_origin_y;
                    r_pen_x   <= r_s1_origin_x;
                    r_pen_y   <= r_s1_origin_y;
                    r_color   <= r_s1_color;
                end
                btl_pkg::OP_CHAR: begin
                    if (r_s1_newline) begin
                        r_pen_x <= r_start_x;
                        r_pen_y <= r_pen_y + COORD_BITS'(r_line_height);
                    end else begin
                        r_pen_x <= r_pen_x + COORD_BITS'(s1_entry.width);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign meas_w      = r_pen_x - r_start_x;
    assign meas_h      = r_pen_y - r_start_y + COORD_BITS'(r_line_height);
    assign pen_x_wide  = 32'(r_pen_x);
    assign pen_y_wide  = 32'(r_pen_y);
    assign meas_w_wide = 32'(meas_w);
    assign meas_h_wide = 32'(meas_h);

    always_comb begin
        n_out_data = '0;
        n_out_kind = btl_pkg::KIND_SPRITE;
        if (r_s1_op == btl_pkg::OP_END) begin
            n_out_kind                 = btl_pkg::KIND_DIMS;
            n_out_data.measured_width  = meas_w_wide[15:0];
            n_out_data.measured_height = meas_h_wide[15:0];
        end else begin
            n_out_data.dest_x        = pen_x_wide[15:0];
            n_out_data.dest_y        = pen_y_wide[15:0];
            n_out_data.sprite_width  = s1_entry.width;
            n_out_data.sprite_height = r_line_height;
            n_out_data.source_x      = s1_entry.atlas_x;
            n_out_data.source_y      = s1_entry.atlas_y;
            n_out_data.draw_color    = r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_has_result) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule

`default_nettype wire

>>> rtl/btl_glyph_ram.sv
// Glyph table memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module btl_glyph_ram #(
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_BITS-1:0]  i_wr_addr,
    input  wire btl_pkg::t_glyph_entry i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_BITS-1:0]  i_rd_addr,
    output btl_pkg::t_glyph_entry      o_rd_data
);

    btl_pkg::t_glyph_entry r_mem [DEPTH];
    btl_pkg::t_glyph_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/btl_checker.sv
// Port-level checker for the bitmap text layout block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_text_layout_assert.svh"

module btl_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [7:0]                        i_cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [btl_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input  wire logic [1:0]                        s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [btl_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input  wire logic                              m_axis_tuser
);

    logic unused_inputs;
    assign unused_inputs = i_cfg_wr_en ^ (^i_cfg_wr_data) ^ s_axis_tvalid ^ s_axis_tready
                         ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    `BTL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `BTL_ASSERT_IMP(a_dims_clean, m_axis_tvalid && (m_axis_tuser == btl_pkg::KIND_DIMS),
        (m_axis_tdata[101:0] == '0) && (m_axis_tdata[135:134] == '0))

    `BTL_ASSERT_IMP(a_sprite_clean, m_axis_tvalid && (m_axis_tuser == btl_pkg::KIND_SPRITE),
        m_axis_tdata[135:102] == '0)

    `BTL_ASSERT_IMP(a_no_out_after_reset, !$past(i_rst_n), !m_axis_tvalid)

endmodule

bind bitmap_text_layout btl_checker u_btl_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for bitmap_text_layout: random glyph fill, table-driven directed rows, random text runs.
`timescale 1ns / 1ps

module tb_top;
    import btl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1620;
    localparam int PHASES       = 6;

    localparam logic [1:0] CLASS_SPACING = 2'd2;
    localparam logic [1:0] CLASS_THREE   = 2'd3;

    typedef struct packed {
        logic    kind;
        t_result data;
    } t_layout_out;

    typedef struct {
        t_opcode     op;
        t_in_data    data;
        bit          fixed;
        t_layout_out want;
    } t_step_row;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [7:0]               i_cfg_wr_data = 8'd0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // char_code, glyph_width, glyph_atlas_x, glyph_atlas_y, glyph_class,
    // origin_x, origin_y, text_color
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [1:0]               s_axis_tuser  = '0;   // opcode
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // dest_x, dest_y, sprite_width, sprite_height, source_x, source_y,
    // draw_color, measured_width, measured_height, two zero bits
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tuser;         // result_kind

    t_glyph_entry glyph_rom [256];
    logic [15:0]  pen_x, pen_y, org_x, org_y;
    logic [31:0]  pen_color;
    logic [7:0]   line_h;

    t_layout_out pending_results[$];
    t_step_row   directed_rows[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    bitmap_text_layout dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit layout_step(input t_opcode op, input t_in_data d,
                                       output t_layout_out res);
        t_glyph_entry g;
        res = '0;
        case (op)
            OP_WRITE: begin
                g.width       = d.glyph_width;
                g.atlas_x     = d.glyph_atlas_x;
                g.atlas_y     = d.glyph_atlas_y;
                g.glyph_class = d.glyph_class;
                glyph_rom[d.char_code] = g;
                return 1'b0;
            end
            OP_BEGIN: begin
                org_x     = d.origin_x;
                org_y     = d.origin_y;
                pen_x     = d.origin_x;
                pen_y     = d.origin_y;
                pen_color = d.text_color;
                return 1'b0;
            end
            OP_END: begin
                res.kind                 = KIND_DIMS;
                res.data.measured_width  = pen_x - org_x;
                res.data.measured_height = pen_y - org_y + 16'(line_h);
                return 1'b1;
            end
            default: begin
                if (d.char_code == CHAR_NEWLINE) begin
                    pen_x = org_x;
                    pen_y = pen_y + 16'(line_h);
                    return 1'b0;
                end
                g = glyph_rom[d.char_code];
                if (g.glyph_class == CLASS_MISSING) begin
                    g = glyph_rom[CHAR_QUESTION];
                end
                res.kind               = KIND_SPRITE;
                res.data.dest_x        = pen_x;
                res.data.dest_y        = pen_y;
                res.data.sprite_width  = g.width;
                res.data.sprite_height = line_h;
                res.data.source_x      = g.atlas_x;
                res.data.source_y      = g.atlas_y;
                res.data.draw_color    = pen_color;
                pen_x = pen_x + 16'(g.width);
                return g.glyph_class == CLASS_DRAWABLE;
            end
        endcase
    endfunction

    function automatic t_in_data glyph_item(input logic [7:0] code, input logic [7:0] w,
                                            input logic [10:0] ax, input logic [10:0] ay,
                                            input logic [1:0] cls);
        t_in_data d;
        d               = '0;
        d.char_code     = code;
        d.glyph_width   = w;
        d.glyph_atlas_x = ax;
        d.glyph_atlas_y = ay;
        d.glyph_class   = cls;
        return d;
    endfunction

    function automatic t_in_data begin_item(input logic [15:0] ox, input logic [15:0] oy,
                                            input logic [31:0] color);
        t_in_data d;
        d            = '0;
        d.origin_x   = ox;
        d.origin_y   = oy;
        d.text_color = color;
        return d;
    endfunction

    function automatic t_in_data code_item(input logic [7:0] code);
        t_in_data d;
        d           = '0;
        d.char_code = code;
        return d;
    endfunction

    function automatic t_layout_out sprite_out(input logic [15:0] dx, input logic [15:0] dy,
                                               input logic [7:0] w, input logic [7:0] h,
                                               input logic [10:0] sx, input logic [10:0] sy,
                                               input logic [31:0] color);
        t_layout_out r;
        r                    = '0;
        r.kind               = KIND_SPRITE;
        r.data.dest_x        = dx;
        r.data.dest_y        = dy;
        r.data.sprite_width  = w;
        r.data.sprite_height = h;
        r.data.source_x      = sx;
        r.data.source_y      = sy;
        r.data.draw_color    = color;
        return r;
    endfunction

    function automatic t_layout_out dims_out(input logic [15:0] mw, input logic [15:0] mh);
        t_layout_out r;
        r                      = '0;
        r.kind                 = KIND_DIMS;
        r.data.measured_width  = mw;
        r.data.measured_height = mh;
        return r;
    endfunction

    function automatic logic [1:0] pick_class();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4) return CLASS_MISSING;
        if (r < 14) return CLASS_DRAWABLE;
        if (r < 17) return CLASS_SPACING;
        return CLASS_THREE;
    endfunction

    function automatic t_in_data random_fields();
        t_in_data d;
        d.char_code     = 8'($urandom_range(0, 255));
        d.glyph_width   = 8'($urandom_range(0, 255));
        d.glyph_atlas_x = 11'($urandom_range(0, 2047));
        d.glyph_atlas_y = 11'($urandom_range(0, 2047));
        d.glyph_class   = pick_class();
        d.origin_x      = 16'($urandom);
        d.origin_y      = 16'($urandom);
        d.text_color    = $urandom;
        return d;
    endfunction

    function automatic t_in_data char_fields();
        t_in_data d;
        d = random_fields();
        if ($urandom_range(0, 9) == 0) begin
            d.char_code = CHAR_NEWLINE;
        end
        return d;
    endfunction

    task automatic send_item(input t_opcode op, input t_in_data d, input bit fixed,
                             input t_layout_out want);
        t_layout_out res;
        bit          has_res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        has_res = layout_step(op, d, res);
        if (fixed) begin
            pending_results.push_back(want);
        end else if (has_res) begin
            pending_results.push_back(res);
        end
    endtask

    task automatic send_random_text(input int count);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(OP_WRITE, random_fields(), 1'b0, '0);
                sent++;
            end else if (pick < 12) begin
                send_item(t_opcode'($urandom_range(0, 3)), random_fields(), 1'b0, '0);
                sent++;
            end else begin
                send_item(OP_BEGIN, random_fields(), 1'b0, '0);
                n = $urandom_range(1, 12);
                repeat (n) send_item(OP_CHAR, char_fields(), 1'b0, '0);
                sent += n + 1;
                // Now and then a string is left without its end transfer.
                if ($urandom_range(0, 9) != 0) begin
                    send_item(OP_END, random_fields(), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic settle_and_configure(input logic [7:0] h);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        line_h = h;
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s: expected %h, got %h", fname, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result     got;
        t_layout_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: kind %0d data %h",
                             m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("dest_x", 32'(want.data.dest_x), 32'(got.dest_x));
                check_field("dest_y", 32'(want.data.dest_y), 32'(got.dest_y));
                check_field("sprite_width", 32'(want.data.sprite_width),
                            32'(got.sprite_width));
                check_field("sprite_height", 32'(want.data.sprite_height),
                            32'(got.sprite_height));
                check_field("source_x", 32'(want.data.source_x), 32'(got.source_x));
                check_field("source_y", 32'(want.data.source_y), 32'(got.source_y));
                check_field("draw_color", want.data.draw_color, got.draw_color);
                check_field("measured_width", 32'(want.data.measured_width),
                            32'(got.measured_width));
                check_field("measured_height", 32'(want.data.measured_height),
                            32'(got.measured_height));
                check_field("pad", 32'(want.data.pad), 32'(got.pad));
            end
        end
    end

    // The long hold-off lets the block fill up while the sender keeps offering transfers.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0] h;
        pen_x     = '0;
        pen_y     = '0;
        org_x     = '0;
        org_y     = '0;
        pen_color = '0;
        line_h    = LINE_HEIGHT_RESET;

        directed_rows = '{
            '{OP_END, code_item(8'h00), 1'b1, dims_out(16'd0, 16'd16)},
            '{OP_WRITE, glyph_item(8'h41, 8'd255, 11'd2047, 11'd2047, CLASS_DRAWABLE),
              1'b0, '0},
            '{OP_CHAR, code_item(8'h41), 1'b1,
              sprite_out(16'h0000, 16'h0000, 8'd255, 8'd16, 11'd2047, 11'd2047, 32'h0)},
            '{OP_BEGIN, begin_item(16'h8000, 16'h7FFF, 32'hFFFF_FFFF), 1'b0, '0},
            '{OP_CHAR, code_item(8'h41), 1'b1,
              sprite_out(16'h8000, 16'h7FFF, 8'd255, 8'd16, 11'd2047, 11'd2047,
                         32'hFFFF_FFFF)},
            '{OP_CHAR, code_item(8'h41), 1'b0, '0},
            '{OP_CHAR, code_item(CHAR_NEWLINE), 1'b0, '0},
            '{OP_END, code_item(8'h00), 1'b0, '0},
            '{OP_WRITE, glyph_item(CHAR_QUESTION, 8'd7, 11'd0, 11'd0, CLASS_MISSING),
              1'b0, '0},
            '{OP_WRITE, glyph_item(8'h00, 8'd0, 11'd0, 11'd0, CLASS_MISSING), 1'b0, '0},
            '{OP_CHAR, code_item(8'h00), 1'b0, '0},
            '{OP_WRITE, glyph_item(8'hFF, 8'd200, 11'd1234, 11'd77, CLASS_THREE), 1'b0, '0},
            '{OP_CHAR, code_item(8'hFF), 1'b0, '0},
            '{OP_WRITE, glyph_item(8'h20, 8'd5, 11'd10, 11'd20, CLASS_SPACING), 1'b0, '0},
            '{OP_CHAR, code_item(8'h20), 1'b0, '0},
            '{OP_WRITE, glyph_item(CHAR_QUESTION, 8'd9, 11'd5, 11'd6, CLASS_DRAWABLE),
              1'b0, '0},
            '{OP_CHAR, code_item(8'h00), 1'b0, '0},
            '{OP_WRITE, glyph_item(CHAR_NEWLINE, 8'd50, 11'd1, 11'd2, CLASS_DRAWABLE),
              1'b0, '0},
            '{OP_CHAR, code_item(CHAR_NEWLINE), 1'b0, '0},
            '{OP_END, code_item(8'h00), 1'b0, '0},
            '{OP_BEGIN, begin_item(16'h0000, 16'h0000, 32'h1234_5678), 1'b0, '0},
            '{OP_CHAR, code_item(CHAR_QUESTION), 1'b1,
              sprite_out(16'h0000, 16'h0000, 8'd9, 8'd16, 11'd5, 11'd6, 32'h1234_5678)},
            '{OP_END, code_item(8'h00), 1'b1, dims_out(16'd9, 16'd16)},
            '{OP_CHAR, code_item(CHAR_NEWLINE), 1'b0, '0},
            '{OP_END, code_item(8'h00), 1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 11;
        rx_idle_pct = 74;
        for (int code = 0; code < 256; code++) begin
            send_item(OP_WRITE, glyph_item(8'(code), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                      pick_class()), 1'b0, '0);
        end
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].fixed,
                      directed_rows[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       h = 8'd255;
                1:       h = 8'd1;
                2:       h = 8'd0;
                default: h = 8'($urandom_range(1, 255));
            endcase
            settle_and_configure(h);
            case (phase / 2)
                0: begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 74;
                end
                1: begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 11;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            send_random_text(RANDOM_ITEMS / PHASES);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
